### design/assert_macros.svh
// assertion macros used by the nearest request scheduler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define NRS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define NRS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/nrs_pkg.sv
// shared constants, codes and types of the nearest request scheduler
`timescale 1ns / 1ps
`default_nettype none

package nrs_pkg;

  // default sizes
  localparam int DEF_CAPACITY = 64;
  localparam int DEF_POS_BITS = 16;

  // fixed field widths
  localparam int TYPE_W   = 2;
  localparam int IO_POS_W = 16;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 48;

  // request codes
  localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_SERVE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MOVED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CONSUMED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

  // what the scan found
  typedef struct packed {
    logic at_head;
    logic left;
    logic right;
  } scan_flags_t;

endpackage

`default_nettype wire

### design/nrs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module nrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/nrs_scan.sv
// compare unit that takes one store entry a cycle while ent_valid is high and keeps the nearest neighbors
`timescale 1ns / 1ps
`default_nettype none

module nrs_scan #(
  parameter int POS_BITS = nrs_pkg::DEF_POS_BITS,
  parameter int IDX_W    = 6
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                ent_valid,
  input  wire logic [IDX_W-1:0]    ent_idx,
  input  wire logic [POS_BITS-1:0] ent_pos,
  input  wire logic [POS_BITS-1:0] head,
  output nrs_pkg::scan_flags_t     flags,
  output logic      [IDX_W-1:0]    head_idx,
  output logic      [POS_BITS-1:0] left_pos,
  output logic      [IDX_W-1:0]    left_idx,
  output logic      [POS_BITS-1:0] right_pos,
  output logic      [IDX_W-1:0]    right_idx
);

  import nrs_pkg::*;

  logic is_eq;
  logic is_below;

  // one compare stage against the head
  assign is_eq    = (ent_pos == head);
  assign is_below = (ent_pos < head);

  // found flags
  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags <= '0;
    end else if (ent_valid) begin
      if (is_eq) begin
        flags.at_head <= 1'b1;
      end
      if (is_below) begin
        flags.left <= 1'b1;
      end else begin
        flags.right <= 1'b1;
      end
    end
  end

  // best candidates on each side, first entry at the head
  always_ff @(posedge clk) begin
    if (ent_valid) begin
      if (is_eq && !flags.at_head) begin
        head_idx <= ent_idx;
      end
      if (is_below) begin
        if (!flags.left || ent_pos > left_pos) begin
          left_pos <= ent_pos;
          left_idx <= ent_idx;
        end
      end else begin
        if (!flags.right || ent_pos < right_pos) begin
          right_pos <= ent_pos;
          right_idx <= ent_idx;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/nearest_request_scheduler.sv
// nearest request scheduler: add and clear pass the finish step, then the result register
// serve makes one store read per pending entry through one compare unit
// then decide, compact and result steps; an empty store or an unused type skips to finish
// the next item is taken once the result is staged
// a full result may wait in the output register while the next item is already taken
// reset (synchronous, input stalled) empties the store by fill count, head 0, right, total 0
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nearest_request_scheduler #(
  parameter int CAPACITY = nrs_pkg::DEF_CAPACITY,
  parameter int POS_BITS = nrs_pkg::DEF_POS_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [nrs_pkg::TYPE_W-1:0]    req_type,
  input  wire logic [nrs_pkg::IO_POS_W-1:0]  position,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic      [nrs_pkg::STATUS_W-1:0]  status,
  output logic      [nrs_pkg::IO_POS_W-1:0]  head_position,
  output logic      [nrs_pkg::IO_POS_W-1:0]  distance_moved,
  output logic      [nrs_pkg::TOTAL_W-1:0]   total_distance
);

  import nrs_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_COMPACT = 3'd3;
  localparam logic [2:0] S_FINISH  = 3'd4;

  logic [2:0]          state;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    scan_cnt;
  logic [POS_BITS-1:0] head;
  logic                moving_right;
  logic [TOTAL_W-1:0]  total;
  logic [STATUS_W-1:0] res_status;
  logic [POS_BITS-1:0] res_dist;
  logic [IDX_W-1:0]    pick_idx;

  logic                req_xfer;
  logic                slot_free;
  logic [31:0]         pos_wide;
  logic [POS_BITS-1:0] pos_in;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CNT_W-1:0]    scan_m1;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [POS_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [POS_BITS-1:0] ram_rdata;

  scan_flags_t         sc_flags;
  logic [IDX_W-1:0]    sc_head_idx;
  logic [POS_BITS-1:0] sc_left_pos;
  logic [IDX_W-1:0]    sc_left_idx;
  logic [POS_BITS-1:0] sc_right_pos;
  logic [IDX_W-1:0]    sc_right_idx;
  logic                scan_start;
  logic                scan_ent;

  logic [POS_BITS-1:0] dl;
  logic [POS_BITS-1:0] dr;
  logic                go_right;
  logic [TOTAL_W:0]    total_sum;
  logic [31:0]         head_wide;
  logic [31:0]         dist_wide;

  // handshake
  assign req_stall = rst || (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;

  // keep only the position bits the store holds
  assign pos_wide = 32'(position);
  assign pos_in   = pos_wide[POS_BITS-1:0];

  assign cnt_m1  = count - CNT_ONE;
  assign scan_m1 = scan_cnt - CNT_ONE;

  // pending position store
  nrs_ram #(
    .WIDTH (POS_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // store port control: append on add, move last entry into the hole on removal
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = pos_in;
    ram_raddr = scan_cnt[IDX_W-1:0];
    if (req_xfer && req_type == REQ_ADD && count != CAP_CNT) begin
      ram_we = 1'b1;
    end
    if (state == S_DECIDE) begin
      ram_raddr = cnt_m1[IDX_W-1:0];
    end
    if (state == S_COMPACT) begin
      ram_we    = 1'b1;
      ram_waddr = pick_idx;
      ram_wdata = ram_rdata;
    end
  end

  // shared compare unit
  assign scan_start = req_xfer && req_type == REQ_SERVE;
  assign scan_ent   = (state == S_SCAN) && (scan_cnt != '0);

  nrs_scan #(
    .POS_BITS (POS_BITS),
    .IDX_W    (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .ent_valid (scan_ent),
    .ent_idx   (scan_m1[IDX_W-1:0]),
    .ent_pos   (ram_rdata),
    .head      (head),
    .flags     (sc_flags),
    .head_idx  (sc_head_idx),
    .left_pos  (sc_left_pos),
    .left_idx  (sc_left_idx),
    .right_pos (sc_right_pos),
    .right_idx (sc_right_idx)
  );

  // choice between the two neighbors, ties follow the last direction
  assign dl = head - sc_left_pos;
  assign dr = sc_right_pos - head;
  assign go_right = !sc_flags.left ||
                    (sc_flags.right && ((dr < dl) || (dr == dl && moving_right)));

  // saturating total
  assign total_sum = {1'b0, total} + (TOTAL_W + 1)'(res_dist);

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      scan_cnt     <= '0;
      head         <= '0;
      moving_right <= 1'b1;
      total        <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            scan_cnt <= '0;
            state    <= S_FINISH;
            case (req_type)
              REQ_ADD: begin
                if (count != CAP_CNT) begin
                  count <= count + CNT_ONE;
                end
              end
              REQ_SERVE: begin
                if (count != '0) begin
                  state <= S_SCAN;
                end
              end
              REQ_CLEAR: begin
                count        <= '0;
                head         <= '0;
                moving_right <= 1'b1;
                total        <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_cnt == count) begin
            state <= S_DECIDE;
          end else begin
            scan_cnt <= scan_cnt + CNT_ONE;
          end
        end
        S_DECIDE: begin
          if (sc_flags.at_head) begin
            state <= S_COMPACT;
          end else if (!sc_flags.left && !sc_flags.right) begin
            state <= S_FINISH;
          end else begin
            state        <= S_COMPACT;
            moving_right <= go_right;
            head         <= go_right ? sc_right_pos : sc_left_pos;
          end
        end
        S_COMPACT: begin
          count <= cnt_m1;
          total <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // per-item result status, distance and removal slot
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_xfer) begin
      res_dist <= '0;
      case (req_type)
        REQ_ADD:   res_status <= (count != CAP_CNT) ? ST_ADDED : ST_FULL;
        REQ_SERVE: res_status <= ST_NONE;
        REQ_CLEAR: res_status <= ST_CLEARED;
        default:   res_status <= ST_NONE;
      endcase
    end else if (state == S_DECIDE) begin
      if (sc_flags.at_head) begin
        res_status <= ST_CONSUMED;
        pick_idx   <= sc_head_idx;
      end else if (sc_flags.left || sc_flags.right) begin
        res_status <= ST_MOVED;
        res_dist   <= go_right ? dr : dl;
        pick_idx   <= go_right ? sc_right_idx : sc_left_idx;
      end
    end
  end

  // output register
  assign head_wide = 32'(head);
  assign dist_wide = 32'(res_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FINISH && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && slot_free) begin
      status         <= res_status;
      head_position  <= head_wide[IO_POS_W-1:0];
      distance_moved <= dist_wide[IO_POS_W-1:0];
      total_distance <= total;
    end
  end

  // checks
  `NRS_ASSERT_ALWAYS(a_count_cap, count <= CAP_CNT, "fill count beyond capacity")
  `NRS_ASSERT_IMPL(a_rsp_from_finish, $rose(rsp_valid), $past(state) == S_FINISH,
                   "result raised outside the finish step")
  `NRS_ASSERT_NEXT(a_total_grows, state == S_COMPACT, total >= $past(total),
                   "running total decreased on a serve")
  `NRS_ASSERT_IMPL(a_scan_nonempty, state == S_SCAN, count != '0,
                   "scan started on an empty store")

endmodule

`default_nettype wire
